@@ hw/rtl/rfb_pkg.sv @@
// rfb_pkg: shared types and constants for the radial falloff blob pixel block.
// Word structs for the pixel and result channels, register indexes, datapath widths.
// No dependencies.
package rfb_pkg;

	localparam int POS_W      = 8;   // blob-relative row / column
	localparam int COORD_W    = 16;  // screen coordinates, wrap mod 65536
	localparam int DIA_W      = 9;   // diameter register
	localparam int PEAK_W     = 8;   // intensity / shade
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Radius <= 256, offsets <= 255, so R*R and d fit in 17 bits.
	localparam int RAD_W  = 9;
	localparam int SQ_W   = 2 * POS_W;          // one squared offset
	localparam int DEN_W  = 2 * POS_W + 1;      // R*R, d, R*R-d
	localparam int NUM_W  = PEAK_W + SQ_W;      // peak*(R*R-d) < 2^24
	localparam int QUO_W  = PEAK_W;             // quotient never exceeds peak

	localparam int MAX_DIAMETER_DEF = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOB_DIAMETER  = 2'd0,
		REG_PEAK_INTENSITY = 2'd1,
		REG_ORIGIN_X       = 2'd2,
		REG_ORIGIN_Y       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] blob_row;
		logic [POS_W-1:0] blob_col;
	} pix_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] screen_x;
		logic [COORD_W-1:0] screen_y;
		logic [PEAK_W-1:0]  shade;
	} pix_out_t;

	// Screen position riding alongside the shade computation.
	typedef struct packed {
		logic [COORD_W-1:0] screen_x;
		logic [COORD_W-1:0] screen_y;
	} side_t;

endpackage

@@ hw/rtl/rfb_div.sv @@
// rfb_div: pipelined restoring divider, one quotient bit per stage.
// Quotient is known to fit QUO_W bits (num < den << QUO_W). Carries side_t along.
// Depends on rfb_pkg.
module rfb_div
	import rfb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  side_t            side_in,
	output logic             out_vld,
	output logic [QUO_W-1:0] quo,
	output side_t            side_out
);

	// index k = state after k stages
	logic             vld_s  [0:QUO_W];
	logic [NUM_W-1:0] rem_s  [0:QUO_W];
	logic [DEN_W-1:0] den_s  [0:QUO_W];
	logic [QUO_W-1:0] quo_s  [0:QUO_W];
	side_t            side_s [0:QUO_W];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] dk;
		logic             ge;

		// trial subtrahend: den shifted to the bit this stage resolves
		assign dk = NUM_W'(den_s[k]) << (QUO_W - 1 - k);
		assign ge = rem_s[k] >= dk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_s[k] - dk : rem_s[k];
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QUO_W];
	assign quo      = quo_s[QUO_W];
	assign side_out = side_s[QUO_W];

endmodule

@@ hw/rtl/radial_falloff_blob_pixel.sv @@
// radial_falloff_blob_pixel: top level of the blob pixel shader pipeline.
// Depends on rfb_pkg and rfb_div.
//
// Usage
//   in_*  : one word per blob pixel (blob_row, blob_col). Accepted when
//           in_valid && in_ready.
//   out_* : one word per accepted pixel (screen_x, screen_y, shade), in order.
//   cfg_* : register writes (diameter, peak intensity, origin x/y); cfg_ready
//           is always high. Write only while the pipeline is empty.
// Pipeline: 4 front stages for offsets, squares, distance and numerator, then 8
//   stages of the bit-per-stage divider by R*R.
// Throughput: one word per clock while out_ready is high.
// Stall: the whole pipeline holds when the output word is valid and not taken;
//   in_ready falls in the same cycle, so no word is lost or repeated.
// Reset: arst_n clears all valid bits and loads the register defaults
//   (diameter 1, peak 255, origin 0,0).
//
module radial_falloff_blob_pixel
	import rfb_pkg::*;
#(
	parameter int MAX_DIAMETER = MAX_DIAMETER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pix_in_t               in_data,
	// result words
	output logic                  out_valid,
	input  logic                  out_ready,
	output pix_out_t              out_data,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int          CMP_W   = 12;
	localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_DIAMETER);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [DIA_W-1:0]   dia_q;
	logic [PEAK_W-1:0]  peak_q;
	logic [COORD_W-1:0] org_x_q;
	logic [COORD_W-1:0] org_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dia_q   <= DIA_W'(1);
			peak_q  <= '1;
			org_x_q <= '0;
			org_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BLOB_DIAMETER:  dia_q   <= cfg_data[DIA_W-1:0];
				REG_PEAK_INTENSITY: peak_q  <= cfg_data[PEAK_W-1:0];
				REG_ORIGIN_X:       org_x_q <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:       org_y_q <= cfg_data[COORD_W-1:0];
			endcase
		end
	end

	// global advance: output slot free or being drained
	logic en;
	logic div_vld;
	assign en       = !div_vld || out_ready;
	assign in_ready = en;

	// ---------------------------------------------------------------
	// Stage 1: clamp diameter, radius, mirrored offsets, screen position
	// ---------------------------------------------------------------
	logic [DIA_W-1:0] dia_eff;
	logic [RAD_W-1:0] rad;
	logic             odd;
	logic             in_blob;
	logic [RAD_W-1:0] off_i_w;
	logic [RAD_W-1:0] off_j_w;
	logic [RAD_W-1:0] row_w;
	logic [RAD_W-1:0] col_w;

	assign dia_eff = (CMP_W'(dia_q) > MAX_EXT) ? MAX_EXT[DIA_W-1:0] : dia_q;
	// R = ceil(dia/2); odd diameter shares the centre row, so offsets past it add one
	assign rad     = RAD_W'(dia_eff - (dia_eff >> 1));
	assign odd     = dia_eff[0];
	assign row_w   = RAD_W'(in_data.blob_row);
	assign col_w   = RAD_W'(in_data.blob_col);
	assign in_blob = (DIA_W'(in_data.blob_row) < dia_eff) &&
	                 (DIA_W'(in_data.blob_col) < dia_eff);
	assign off_i_w = (row_w < rad) ? rad - 1'b1 - row_w : row_w - rad + RAD_W'(odd);
	assign off_j_w = (col_w < rad) ? rad - 1'b1 - col_w : col_w - rad + RAD_W'(odd);

	logic             vld_s1;
	logic             ok_s1;
	logic [POS_W-1:0] off_i_s1;
	logic [POS_W-1:0] off_j_s1;
	logic [RAD_W-1:0] rad_s1;
	side_t            side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1            <= in_blob;
			off_i_s1         <= off_i_w[POS_W-1:0];
			off_j_s1         <= off_j_w[POS_W-1:0];
			rad_s1           <= rad;
			side_s1.screen_x <= org_x_q + COORD_W'(in_data.blob_col);
			side_s1.screen_y <= org_y_q + COORD_W'(in_data.blob_row);
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squares i*i, j*j and R*R
	// ---------------------------------------------------------------
	logic             vld_s2;
	logic             ok_s2;
	logic [SQ_W-1:0]  ii_s2;
	logic [SQ_W-1:0]  jj_s2;
	logic [DEN_W-1:0] rr_s2;
	side_t            side_s2;
	logic [2*RAD_W-1:0] rr_w;

	assign rr_w = rad_s1 * rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2   <= ok_s1;
			ii_s2   <= off_i_s1 * off_i_s1;
			jj_s2   <= off_j_s1 * off_j_s1;
			rr_s2   <= rr_w[DEN_W-1:0];
			side_s2 <= side_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: d = i*i + j*j, inside test and R*R - d
	// ---------------------------------------------------------------
	logic [DEN_W-1:0] dist_w;
	logic             vld_s3;
	logic             ok_s3;
	logic [DEN_W-1:0] diff_s3;
	logic [DEN_W-1:0] rr_s3;
	side_t            side_s3;

	assign dist_w = DEN_W'(ii_s2) + DEN_W'(jj_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	// boundary d == R*R falls through with a zero numerator
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3   <= ok_s2 && (dist_w <= rr_s2);
			diff_s3 <= rr_s2 - dist_w;
			rr_s3   <= rr_s2;
			side_s3 <= side_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: numerator peak*(R*R-d); pixels outside the blob or circle divide 0 by 1
	// ---------------------------------------------------------------
	logic [PEAK_W+DEN_W-1:0] prod_w;
	logic             vld_s4;
	logic [NUM_W-1:0] num_s4;
	logic [DEN_W-1:0] den_s4;
	side_t            side_s4;

	assign prod_w = peak_q * diff_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= ok_s3 ? prod_w[NUM_W-1:0] : '0;
			den_s4  <= ok_s3 ? rr_s3 : DEN_W'(1);
			side_s4 <= side_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stages 5..12: divide by R*R; last stage is the output register
	// ---------------------------------------------------------------
	logic [QUO_W-1:0] quo;
	side_t            side_out;

	rfb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side_in  (side_s4),
		.out_vld  (div_vld),
		.quo      (quo),
		.side_out (side_out)
	);

	assign out_valid         = div_vld;
	assign out_data.screen_x = side_out.screen_x;
	assign out_data.screen_y = side_out.screen_y;
	assign out_data.shade    = quo;

endmodule
